// ===== rtl/core/lbca_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the linked block chain allocator.
package lbca_pkg;

  localparam int unsigned MAX_BLOCKS = 4096;
  localparam int unsigned BLK_W      = 12;
  localparam int unsigned CNT_W      = 13;

  typedef enum logic [2:0] {
    OP_FORMAT = 3'd0,
    OP_ALLOC  = 3'd1,
    OP_LINK   = 3'd2,
    OP_NEXT   = 3'd3,
    OP_FREE   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OVERRUN = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  // One link table entry: end-of-chain flag plus next block.
  typedef struct packed {
    logic             last;
    logic [BLK_W-1:0] next;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [BLK_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [BLK_W-1:0] raddr;
  } ram_req_t;

  localparam entry_t END_ENTRY = '{last: 1'b1, next: '0};

endpackage

// ===== rtl/core/lbca_link_ram.sv =====
`timescale 1ns / 1ps
// Link table storage: one write port, one read port with registered read data.
module lbca_link_ram (
  input  logic              clk_i,
  input  lbca_pkg::ram_req_t req_i,
  output lbca_pkg::entry_t   rdata_o
);
  import lbca_pkg::*;

  entry_t mem [MAX_BLOCKS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    // read data holds while no read is issued
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/linked_block_chain_allocator_core.sv =====
`timescale 1ns / 1ps
// Top level of the linked block chain allocator: control sequencer around the link table.
//
//   channel | direction | transfer when          | payload
//   --------+-----------+------------------------+---------------------------------
//   in      | input     | in_valid_i & in_ready_o | op_i, block_i, target_i
//   out     | output    | out_valid_o & out_ready_i | status_o, block_out_o, is_end_o
//   cfg     | input     | cfg_valid_i & cfg_ready_o | cfg_data_i (block_count)
//
// Alloc, link and next: accept with table read, then write-back (alloc, link) and result.
// Free walks the chain one link per cycle through the table read port.
// Format writes one table entry per cycle; the last entry waits until the output register is free.
// Reset clears control state only; the link table holds nothing valid until a format.
// A result waits in the output register; the next item is accepted meanwhile and
// completes once that register is free.
module linked_block_chain_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  op_i,
  input  logic [lbca_pkg::BLK_W-1:0]  block_i,
  input  logic [lbca_pkg::BLK_W-1:0]  target_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [lbca_pkg::BLK_W-1:0]  block_out_o,
  output logic                        is_end_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lbca_pkg::CNT_W-1:0]  cfg_data_i
);
  import lbca_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FMT,
    S_EXEC
  } state_e;

  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] CntOne = CNT_W'(1);

  state_e            state_q, state_d;
  logic [2:0]        op_q, op_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [BLK_W-1:0]  tgt_q, tgt_d;
  status_e           err_q, err_d;
  logic [BLK_W-1:0]  cur_q, cur_d;
  logic [CNT_W-1:0]  step_q, step_d;
  logic [BLK_W-1:0]  idx_q, idx_d;
  logic [BLK_W-1:0]  free_head_q, free_head_d;
  logic              free_empty_q, free_empty_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [BLK_W-1:0]  bout_q, bout_d;
  logic              is_end_q, is_end_d;

  ram_req_t          ram_req;
  entry_t            rd;

  logic              in_fire;
  logic              can_out;
  logic              blk_oor, tgt_oor;
  status_e           acc_err;
  logic              fmt_last;

  lbca_link_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rd)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign can_out     = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign blk_oor  = ({1'b0, block_i} >= cnt_q);
  assign tgt_oor  = ({1'b0, target_i} >= cnt_q);
  assign fmt_last = (({1'b0, idx_q} + CntOne) == cnt_q);

  // errors known at accept time
  always_comb begin
    acc_err = ST_OK;
    case (op_i) inside
      OP_ALLOC: begin
        if (free_empty_q) begin
          acc_err = ST_EMPTY;
        end else if ({1'b0, free_head_q} >= cnt_q) begin
          acc_err = ST_RANGE;
        end
      end
      OP_LINK: begin
        if (blk_oor || tgt_oor) acc_err = ST_RANGE;
      end
      OP_NEXT, OP_FREE: begin
        if (blk_oor) acc_err = ST_RANGE;
      end
      default: acc_err = ST_OK;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    blk_d        = blk_q;
    tgt_d        = tgt_q;
    err_d        = err_q;
    cur_d        = cur_q;
    step_d       = step_q;
    idx_d        = idx_q;
    free_head_d  = free_head_q;
    free_empty_d = free_empty_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    bout_d       = bout_q;
    is_end_d     = is_end_q;
    ram_req      = '{we: 1'b0, waddr: '0, wdata: '0, re: 1'b0, raddr: '0};

    if (cfg_valid_i) begin
      if (cfg_data_i == '0) begin
        cnt_d = CntOne;
      end else if (cfg_data_i > CntMax) begin
        cnt_d = CntMax;
      end else begin
        cnt_d = cfg_data_i;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d   = op_i;
          blk_d  = block_i;
          tgt_d  = target_i;
          err_d  = acc_err;
          cur_d  = block_i;
          step_d = '0;
          idx_d  = '0;
          ram_req.re    = 1'b1;
          ram_req.raddr = (op_i == OP_ALLOC) ? free_head_q : block_i;
          state_d = (op_i == OP_FORMAT) ? S_FMT : S_EXEC;
        end
      end

      S_FMT: begin
        ram_req.waddr = idx_q;
        ram_req.wdata = fmt_last ? END_ENTRY : entry_t'{last: 1'b0, next: idx_q + 1'b1};
        if (!fmt_last) begin
          ram_req.we = 1'b1;
          idx_d      = idx_q + 1'b1;
        end else if (can_out) begin
          ram_req.we   = 1'b1;
          free_head_d  = '0;
          free_empty_d = 1'b0;
          out_valid_d  = 1'b1;
          status_d     = ST_OK;
          bout_d       = '0;
          is_end_d     = 1'b0;
          state_d      = S_IDLE;
        end
      end

      S_EXEC: begin
        if (err_q != ST_OK) begin
          if (can_out) begin
            out_valid_d = 1'b1;
            status_d    = err_q;
            bout_d      = '0;
            is_end_d    = 1'b0;
            state_d     = S_IDLE;
          end
        end else begin
          case (op_q)
            OP_ALLOC: begin
              if (can_out) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = free_head_q;
                ram_req.wdata = END_ENTRY;
                if (rd.last) begin
                  free_empty_d = 1'b1;
                end else begin
                  free_head_d = rd.next;
                end
                out_valid_d = 1'b1;
                status_d    = ST_OK;
                bout_d      = free_head_q;
                is_end_d    = 1'b0;
                state_d     = S_IDLE;
              end
            end
            OP_LINK: begin
              if (can_out) begin
                ram_req.we    = 1'b1;
                ram_req.waddr = blk_q;
                ram_req.wdata = '{last: 1'b0, next: tgt_q};
                out_valid_d   = 1'b1;
                status_d      = ST_OK;
                bout_d        = '0;
                is_end_d      = 1'b0;
                state_d       = S_IDLE;
              end
            end
            OP_NEXT: begin
              if (can_out) begin
                out_valid_d = 1'b1;
                status_d    = ST_OK;
                bout_d      = rd.last ? '0 : rd.next;
                is_end_d    = rd.last;
                state_d     = S_IDLE;
              end
            end
            OP_FREE: begin
              if (rd.last) begin
                // splice the old free list behind the chain end
                if (can_out) begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = cur_q;
                  ram_req.wdata = free_empty_q ? END_ENTRY
                                               : entry_t'{last: 1'b0, next: free_head_q};
                  free_head_d   = blk_q;
                  free_empty_d  = 1'b0;
                  out_valid_d   = 1'b1;
                  status_d      = ST_OK;
                  bout_d        = '0;
                  is_end_d      = 1'b0;
                  state_d       = S_IDLE;
                end
              end else if ({1'b0, rd.next} >= cnt_q) begin
                if (can_out) begin
                  out_valid_d = 1'b1;
                  status_d    = ST_RANGE;
                  bout_d      = '0;
                  is_end_d    = 1'b0;
                  state_d     = S_IDLE;
                end
              end else if ((step_q + CntOne) == cnt_q) begin
                // count links read without an end mark: a loop in the chain
                if (can_out) begin
                  out_valid_d = 1'b1;
                  status_d    = ST_OVERRUN;
                  bout_d      = '0;
                  is_end_d    = 1'b0;
                  state_d     = S_IDLE;
                end
              end else begin
                cur_d         = rd.next;
                step_d        = step_q + CntOne;
                ram_req.re    = 1'b1;
                ram_req.raddr = rd.next;
              end
            end
            default: begin
              if (can_out) begin
                out_valid_d = 1'b1;
                status_d    = ST_OK;
                bout_d      = '0;
                is_end_d    = 1'b0;
                state_d     = S_IDLE;
              end
            end
          endcase
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= '0;
      blk_q        <= '0;
      tgt_q        <= '0;
      err_q        <= ST_OK;
      cur_q        <= '0;
      step_q       <= '0;
      idx_q        <= '0;
      free_head_q  <= '0;
      free_empty_q <= 1'b1;
      cnt_q        <= CntMax;
      out_valid_q  <= 1'b0;
      status_q     <= ST_OK;
      bout_q       <= '0;
      is_end_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      blk_q        <= blk_d;
      tgt_q        <= tgt_d;
      err_q        <= err_d;
      cur_q        <= cur_d;
      step_q       <= step_d;
      idx_q        <= idx_d;
      free_head_q  <= free_head_d;
      free_empty_q <= free_empty_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      bout_q       <= bout_d;
      is_end_q     <= is_end_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign block_out_o = bout_q;
  assign is_end_o    = is_end_q;

  // an accepted item always leaves the idle state in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("accepted item did not start processing");

  // the table is never written while the block waits for an item
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> state_q != S_IDLE)
    else $error("link table written while idle");

  // the chain walk never reads more links than there are blocks
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> step_q < cnt_q)
    else $error("chain walk step count out of bounds");

  // effective block count stays clamped
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (cnt_q != '0) && (cnt_q <= CntMax))
    else $error("block count outside its range");

endmodule
